@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers shared by the scanner RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |-> (cons), msg)

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    `ASSERT_CLK(label, (ante) |=> (cons), msg)

`endif

@@ src/sss_pkg.sv @@
// ----------------------------------------------------------------------------
// sss_pkg
// Types and constants of the shellcode signature stream scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sss_pkg;

    localparam int HIST_DEPTH = 5;
    localparam int NUM_FLAGS  = 6;

    typedef logic [NUM_FLAGS-1:0] flags_t;

    localparam int FLAG_NOP   = 0;
    localparam int FLAG_GETPC = 1;
    localparam int FLAG_X64   = 2;
    localparam int FLAG_API   = 3;
    localparam int FLAG_SYS   = 4;
    localparam int FLAG_ROP   = 5;

    // configuration register indexes
    localparam logic [2:0] CFG_NOP_SLED_MIN  = 3'd0;
    localparam logic [2:0] CFG_ROP_MIN_GAP   = 3'd1;
    localparam logic [2:0] CFG_ROP_MAX_GAP   = 3'd2;
    localparam logic [2:0] CFG_ROP_MIN_CHAIN = 3'd3;
    localparam logic [2:0] CFG_ROP_MIN_SIZE  = 3'd4;

    localparam logic [15:0] RST_NOP_SLED_MIN  = 16'd16;
    localparam logic [4:0]  RST_ROP_MIN_GAP   = 5'd2;
    localparam logic [4:0]  RST_ROP_MAX_GAP   = 5'd20;
    localparam logic [7:0]  RST_ROP_MIN_CHAIN = 8'd5;
    localparam logic [7:0]  RST_ROP_MIN_SIZE  = 8'd64;

    // opcode bytes
    localparam logic [7:0] OP_NOP     = 8'h90;
    localparam logic [7:0] OP_OPSIZE  = 8'h66;
    localparam logic [7:0] OP_ESC     = 8'h0F;
    localparam logic [7:0] OP_LONGNOP = 8'h1F;
    localparam logic [7:0] OP_RET     = 8'hC3;
    localparam logic [7:0] OP_CALL    = 8'hE8;
    localparam logic [7:0] OP_POP_RAX = 8'h58;
    localparam logic [7:0] OP_POP_RBX = 8'h5B;
    localparam logic [7:0] OP_POP_RCX = 8'h59;
    localparam logic [7:0] OP_JMP_S   = 8'hEB;
    localparam logic [7:0] OP_JMP_OFS = 8'h1A;
    localparam logic [7:0] OP_CLD     = 8'hFC;
    localparam logic [7:0] OP_REX_W   = 8'h48;
    localparam logic [7:0] OP_LEA     = 8'h8D;
    localparam logic [7:0] OP_RIP_RAX = 8'h05;
    localparam logic [7:0] OP_ROT_IB  = 8'hC1;
    localparam logic [7:0] OP_ROT_1   = 8'hD1;
    localparam logic [7:0] OP_ROR_EAX = 8'hC8;
    localparam logic [7:0] OP_ROL_EAX = 8'hC0;
    localparam logic [7:0] OP_SYSCALL = 8'h05;
    localparam logic [7:0] OP_SYSENT  = 8'h34;
    localparam logic [7:0] OP_INT     = 8'hCD;
    localparam logic [7:0] OP_INT_2E  = 8'h2E;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_AFTER66,
        PH_AFTER0F,
        PH_MODRM,
        PH_SKIP
    } nop_phase_t;

    // one byte leaving the input register
    typedef struct packed {
        logic fire;
        logic last;
    } step_t;

endpackage

@@ src/sss_if.sv @@
// ----------------------------------------------------------------------------
// sss_if
// Valid/ready channels for scanned bytes and for per-buffer flag results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sss_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       last_byte;
    logic       private_region;

    modport source (output valid, byte_value, last_byte, private_region, input ready);
    modport sink   (input valid, byte_value, last_byte, private_region, output ready);
endinterface

interface sss_flags_if;
    logic valid;
    logic ready;
    logic nop_sled_found;
    logic getpc_found;
    logic x64_found;
    logic api_hash_found;
    logic syscall_found;
    logic rop_chain_found;

    modport source (output valid, nop_sled_found, getpc_found, x64_found, api_hash_found,
                    syscall_found, rop_chain_found, input ready);
    modport sink   (input valid, nop_sled_found, getpc_found, x64_found, api_hash_found,
                    syscall_found, rop_chain_found, output ready);
endinterface

@@ src/sss_nop_tracker.sv @@
// ----------------------------------------------------------------------------
// sss_nop_tracker
// Decodes 90, 66 90 and 0F 1F long NOPs, skips ModRM/SIB/disp bytes and
// keeps the saturating length of the current NOP run.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sss_nop_tracker
    import sss_pkg::*;
#(
    parameter int RUN_W = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  step_t       step,
    input  logic [7:0]  byte_value,
    input  logic [15:0] sled_min,
    output logic        sled_hit
);

    localparam int CMP_W = (RUN_W > 16) ? RUN_W : 16;

    nop_phase_t       phase_reg, phase_next;
    logic [2:0]       skip_reg, skip_next;
    logic [RUN_W-1:0] run_reg, run_next;

    logic [1:0]       modrm_mod;
    logic [2:0]       modrm_extra;
    logic [2:0]       skip_dec;
    logic             hit;
    logic             clr;
    logic [RUN_W-1:0] run_base;

    assign modrm_mod = byte_value[7:6];
    assign skip_dec  = (skip_reg != 3'd0) ? skip_reg - 3'd1 : 3'd0;

    always_comb
    begin
        modrm_extra = 3'd0;
        if (modrm_mod != 2'd3)
        begin
            if (byte_value[2:0] == 3'd4)
                modrm_extra = 3'd1;
            if (modrm_mod == 2'd1)
                modrm_extra = modrm_extra + 3'd1;
            else if (modrm_mod == 2'd2)
                modrm_extra = modrm_extra + 3'd4;
        end
    end

    // next phase
    always_comb
    begin
        phase_next = PH_IDLE;
        skip_next  = skip_reg;
        case (phase_reg)
            PH_MODRM:
            begin
                skip_next  = modrm_extra;
                phase_next = (modrm_extra != 3'd0) ? PH_SKIP : PH_IDLE;
            end
            PH_SKIP:
            begin
                skip_next  = skip_dec;
                phase_next = (skip_dec != 3'd0) ? PH_SKIP : PH_IDLE;
            end
            default:
            begin
                if (phase_reg == PH_AFTER66 && byte_value == OP_NOP)
                    phase_next = PH_IDLE;
                else if (phase_reg == PH_AFTER0F && byte_value == OP_LONGNOP)
                    phase_next = PH_MODRM;
                else if (byte_value == OP_OPSIZE)
                    phase_next = PH_AFTER66;
                else if (byte_value == OP_ESC)
                    phase_next = PH_AFTER0F;
                else
                    phase_next = PH_IDLE;
            end
        endcase
    end

    // run length
    always_comb
    begin
        hit = 1'b0;
        clr = 1'b0;
        case (phase_reg)
            PH_AFTER66:
            begin
                hit = (byte_value == OP_NOP);
                clr = !hit;
            end
            PH_AFTER0F:
            begin
                clr = (byte_value != OP_LONGNOP);
                hit = (byte_value == OP_LONGNOP) || (byte_value == OP_NOP);
            end
            PH_MODRM, PH_SKIP:
            begin
                hit = 1'b0;
                clr = 1'b0;
            end
            default:
            begin
                hit = (byte_value == OP_NOP);
                clr = !hit && (byte_value != OP_OPSIZE) && (byte_value != OP_ESC);
            end
        endcase
        run_base = clr ? '0 : run_reg;
        if (hit && run_base != '1)
            run_next = run_base + 1'b1;
        else
            run_next = run_base;
    end

    assign sled_hit = hit && (CMP_W'(run_next) >= CMP_W'(sled_min));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            skip_reg  <= 3'd0;
            run_reg   <= '0;
        end
        else if (step.fire)
        begin
            if (step.last)
            begin
                phase_reg <= PH_IDLE;
                skip_reg  <= 3'd0;
                run_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                skip_reg  <= skip_next;
                run_reg   <= run_next;
            end
        end
    end

    `ASSERT_IMPL(a_skip_live, phase_reg == PH_SKIP, skip_reg != 3'd0,
                 "skip phase with nothing left to skip")
    `ASSERT_IMPL(a_skip_idle, phase_reg != PH_SKIP, skip_reg == 3'd0,
                 "skip count left over outside skip phase")
    `ASSERT_IMPL(a_skip_range, 1'b1, skip_reg <= 3'd5,
                 "skip count beyond SIB plus disp32")

endmodule

@@ src/shellcode_signature_stream_scan.sv @@
// ----------------------------------------------------------------------------
// shellcode_signature_stream_scan
// Byte-stream shellcode scanner: six sticky flags per buffer.
// ----------------------------------------------------------------------------
// Takes one byte per clock on byte_ch, with no gaps needed between buffers.
// A transfer lands in an input register and is scored from there; the whole
// per-byte update (history compares, NOP decode, return chain counters) is
// combinational. The flag transfer for a buffer is offered on flag_ch from
// the result register, loaded when its last byte is scored, and the next
// buffer streams in meanwhile; only a last byte waits while the previous
// result is still unclaimed. Configuration writes belong between buffers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module shellcode_signature_stream_scan
    import sss_pkg::*;
#(
    parameter int RUN_COUNT_WIDTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    sss_byte_if.sink    byte_ch,
    sss_flags_if.source flag_ch
);

    // configuration
    logic [15:0] sled_min_reg;
    logic [4:0]  min_gap_reg;
    logic [4:0]  max_gap_reg;
    logic [7:0]  min_chain_reg;
    logic [7:0]  min_size_reg;

    // input register
    logic        in_vld_reg;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic        in_priv_reg;

    // per-buffer state
    logic [HIST_DEPTH-1:0][7:0] hist_reg;
    logic [2:0]  hist_cnt_reg;
    logic [4:0]  gap_reg, gap_next;
    logic        ret_seen_reg;
    logic [7:0]  chain_reg, chain_next;
    logic [7:0]  count_reg, count_next;
    flags_t      flags_reg, flags_next;

    // result register
    logic        out_vld_reg;
    flags_t      out_flags_reg;
    flags_t      result;

    logic        out_free;
    logic        proc_fire;
    step_t       step;
    logic        sled_hit;
    logic [7:0]  b;
    logic        is_ret;
    logic [5:0]  gap_dist;
    logic        in_window;
    logic        cp_hit;
    logic        jp_hit;
    logic        cld_hit;
    logic        lea_hit;
    logic        api_hit;
    logic        sys_hit;

    assign out_free  = !out_vld_reg || flag_ch.ready;
    assign proc_fire = in_vld_reg && (!in_last_reg || out_free);
    assign byte_ch.ready = !in_vld_reg || proc_fire;
    assign step.fire = proc_fire;
    assign step.last = in_last_reg;
    assign b = in_byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sled_min_reg  <= RST_NOP_SLED_MIN;
            min_gap_reg   <= RST_ROP_MIN_GAP;
            max_gap_reg   <= RST_ROP_MAX_GAP;
            min_chain_reg <= RST_ROP_MIN_CHAIN;
            min_size_reg  <= RST_ROP_MIN_SIZE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_NOP_SLED_MIN:  sled_min_reg  <= cfg_data;
                CFG_ROP_MIN_GAP:   min_gap_reg   <= cfg_data[4:0];
                CFG_ROP_MAX_GAP:   max_gap_reg   <= cfg_data[4:0];
                CFG_ROP_MIN_CHAIN: min_chain_reg <= cfg_data[7:0];
                CFG_ROP_MIN_SIZE:  min_size_reg  <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (byte_ch.ready)
            in_vld_reg <= byte_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (byte_ch.valid && byte_ch.ready)
        begin
            in_byte_reg <= byte_ch.byte_value;
            in_last_reg <= byte_ch.last_byte;
            in_priv_reg <= byte_ch.private_region;
        end
    end

    sss_nop_tracker #(
        .RUN_W (RUN_COUNT_WIDTH)
    ) u_nop (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .byte_value (b),
        .sled_min   (sled_min_reg),
        .sled_hit   (sled_hit)
    );

    // signature window: history plus the current byte
    always_comb
    begin
        cp_hit  = (hist_cnt_reg >= 3'd5) && (hist_reg[4] == OP_CALL) &&
                  (hist_reg[3] == 8'h00) && (hist_reg[2] == 8'h00) &&
                  (hist_reg[1] == 8'h00) && (hist_reg[0] == 8'h00) &&
                  (b == OP_POP_RAX || b == OP_POP_RBX || b == OP_POP_RCX);
        jp_hit  = (hist_cnt_reg >= 3'd2) && (hist_reg[1] == OP_JMP_S) &&
                  (hist_reg[0] == OP_JMP_OFS) && (b == OP_POP_RBX);
        cld_hit = (hist_cnt_reg >= 3'd1) && (hist_reg[0] == OP_CLD) && (b == OP_CALL);
        lea_hit = (hist_cnt_reg >= 3'd2) && (hist_reg[1] == OP_REX_W) &&
                  (hist_reg[0] == OP_LEA) && (b == OP_RIP_RAX);
        api_hit = (hist_cnt_reg >= 3'd1) &&
                  (hist_reg[0] == OP_ROT_IB || hist_reg[0] == OP_ROT_1) &&
                  (b == OP_ROR_EAX || b == OP_ROL_EAX);
        sys_hit = (hist_cnt_reg >= 3'd1) &&
                  ((hist_reg[0] == OP_ESC && (b == OP_SYSCALL || b == OP_SYSENT)) ||
                   (hist_reg[0] == OP_INT && b == OP_INT_2E));
    end

    // return chain
    assign is_ret    = (b == OP_RET);
    assign gap_dist  = {1'b0, gap_reg} + 6'd1;
    assign in_window = (gap_reg != 5'd31) && (gap_dist >= {1'b0, min_gap_reg}) &&
                       (gap_dist <= {1'b0, max_gap_reg});

    always_comb
    begin
        gap_next   = gap_reg;
        chain_next = chain_reg;
        if (!is_ret)
        begin
            if (ret_seen_reg && gap_reg != 5'd31)
                gap_next = gap_reg + 5'd1;
        end
        else
        begin
            gap_next = 5'd0;
            if (ret_seen_reg && in_window)
                chain_next = (chain_reg != 8'd255) ? chain_reg + 8'd1 : chain_reg;
            else
                chain_next = 8'd1;
        end
        count_next = (count_reg != 8'd255) ? count_reg + 8'd1 : count_reg;

        flags_next = flags_reg;
        if (sled_hit)
            flags_next[FLAG_NOP] = 1'b1;
        if (cp_hit || jp_hit || cld_hit || lea_hit)
            flags_next[FLAG_GETPC] = 1'b1;
        if (lea_hit)
            flags_next[FLAG_X64] = 1'b1;
        if (api_hit)
            flags_next[FLAG_API] = 1'b1;
        if (sys_hit)
            flags_next[FLAG_SYS] = 1'b1;
        if (is_ret && chain_next >= min_chain_reg)
            flags_next[FLAG_ROP] = 1'b1;

        result = flags_next;
        result[FLAG_NOP] = flags_next[FLAG_NOP] || (sled_min_reg == 16'd0);
        result[FLAG_ROP] = (flags_next[FLAG_ROP] || (min_chain_reg == 8'd0)) &&
                           in_priv_reg && (count_next >= min_size_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_reg     <= '0;
            hist_cnt_reg <= 3'd0;
            gap_reg      <= 5'd0;
            ret_seen_reg <= 1'b0;
            chain_reg    <= 8'd0;
            count_reg    <= 8'd0;
            flags_reg    <= '0;
        end
        else if (proc_fire)
        begin
            if (in_last_reg)
            begin
                hist_reg     <= '0;
                hist_cnt_reg <= 3'd0;
                gap_reg      <= 5'd0;
                ret_seen_reg <= 1'b0;
                chain_reg    <= 8'd0;
                count_reg    <= 8'd0;
                flags_reg    <= '0;
            end
            else
            begin
                hist_reg     <= {hist_reg[HIST_DEPTH-2:0], b};
                hist_cnt_reg <= (hist_cnt_reg < 3'(HIST_DEPTH)) ? hist_cnt_reg + 3'd1
                                                                 : hist_cnt_reg;
                gap_reg      <= gap_next;
                ret_seen_reg <= ret_seen_reg || is_ret;
                chain_reg    <= chain_next;
                count_reg    <= count_next;
                flags_reg    <= flags_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (proc_fire && in_last_reg)
            out_vld_reg <= 1'b1;
        else if (flag_ch.ready)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire && in_last_reg)
            out_flags_reg <= result;
    end

    assign flag_ch.valid           = out_vld_reg;
    assign flag_ch.nop_sled_found  = out_flags_reg[FLAG_NOP];
    assign flag_ch.getpc_found     = out_flags_reg[FLAG_GETPC];
    assign flag_ch.x64_found       = out_flags_reg[FLAG_X64];
    assign flag_ch.api_hash_found  = out_flags_reg[FLAG_API];
    assign flag_ch.syscall_found   = out_flags_reg[FLAG_SYS];
    assign flag_ch.rop_chain_found = out_flags_reg[FLAG_ROP];

    `ASSERT_NEXT(a_last_makes_result, proc_fire && in_last_reg, out_vld_reg,
                 "last byte scored but no result offered")
    `ASSERT_NEXT(a_last_clears_state, proc_fire && in_last_reg,
                 count_reg == 8'd0 && flags_reg == '0 && !ret_seen_reg,
                 "buffer state not cleared after last byte")
    `ASSERT_IMPL(a_no_overwrite, out_vld_reg && !flag_ch.ready, !(proc_fire && in_last_reg),
                 "pending result overwritten")
    `ASSERT_IMPL(a_x64_implies_getpc, flags_reg[FLAG_X64], flags_reg[FLAG_GETPC],
                 "x64 flag without getpc flag")

endmodule
